[sv/ccm_pkg.sv]
// ----------------------------------------------------------------------------
// ccm_pkg
// shared constants, codes and control types of the coordinate compression map
// ----------------------------------------------------------------------------
package ccm_pkg;

  localparam int unsigned N_ENTRIES = 1024;
  localparam int unsigned AW = $clog2(N_ENTRIES);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned VW = 31;
  localparam int unsigned KW = 2;

  localparam logic [KW-1:0] K_LOAD  = 2'd0;
  localparam logic [KW-1:0] K_CLOSE = 2'd1;
  localparam logic [KW-1:0] K_MAP   = 2'd2;

  typedef enum logic [1:0] {
    RD_I,
    RD_IM1,
    RD_JM1,
    RD_MID
  } rd_sel_t;

  typedef struct packed {
    logic    ld;
    logic    cap;
    logic    sort_init;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    key_ld;
    logic    sort_shift;
    logic    sort_place;
    logic    dd_init;
    logic    dd_step;
    logic    dd_fin;
    logic    mid_ld;
    logic    ms_step;
    logic    out_ld;
  } cmd_t;

  typedef struct packed {
    logic i_ge_n;
    logic j_zero;
    logic rd_gt_key;
    logic lo_ge_hi;
    logic hit;
    logic out_free;
  } status_t;

endpackage

[sv/ccm_if.sv]
// ----------------------------------------------------------------------------
// ccm channel interfaces
// valid/ready channels for input items and results
// ----------------------------------------------------------------------------
interface ccm_in_if;
  logic                 valid;
  logic                 ready;
  logic [1:0]           kind;
  logic [30:0]          value;
  modport source (output valid, kind, value, input ready);
  modport sink   (input valid, kind, value, output ready);
endinterface

interface ccm_out_if;
  logic        valid;
  logic        ready;
  logic [9:0]  rank;
  logic        found;
  logic [10:0] unique_count;
  logic        overflow;
  modport source (output valid, rank, found, unique_count, overflow, input ready);
  modport sink   (input valid, rank, found, unique_count, overflow, output ready);
endinterface

[sv/ccm_ctrl.sv]
// ----------------------------------------------------------------------------
// ccm_ctrl
// sequencer for load, sort, dedupe and binary search
// ----------------------------------------------------------------------------
module ccm_ctrl
  import ccm_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [KW-1:0]   in_kind,
  output logic            in_ready,
  input  status_t         st,
  output cmd_t            cmd
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_SORT_I = 10'b0000000010,
    S_SORT_K = 10'b0000000100,
    S_SORT_C = 10'b0000001000,
    S_SORT_R = 10'b0000010000,
    S_DD_I   = 10'b0000100000,
    S_DD_C   = 10'b0001000000,
    S_MS     = 10'b0010000000,
    S_MC     = 10'b0100000000,
    S_OUT    = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    cmd.rd_sel = RD_I;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_kind)
            K_LOAD: cmd.ld = 1'b1;
            K_CLOSE: begin
              cmd.sort_init = 1'b1;
              state_nxt     = S_SORT_I;
            end
            K_MAP: begin
              cmd.cap   = 1'b1;
              state_nxt = S_MS;
            end
            default: ;
          endcase
        end
      end
      S_SORT_I: begin
        if (st.i_ge_n) begin
          cmd.dd_init = 1'b1;
          state_nxt   = S_DD_I;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_I;
          state_nxt  = S_SORT_K;
        end
      end
      S_SORT_K: begin
        cmd.key_ld = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_IM1;
        state_nxt  = S_SORT_C;
      end
      S_SORT_C: begin
        if (st.rd_gt_key) begin
          cmd.sort_shift = 1'b1;
          state_nxt      = S_SORT_R;
        end else begin
          cmd.sort_place = 1'b1;
          state_nxt      = S_SORT_I;
        end
      end
      S_SORT_R: begin
        if (st.j_zero) begin
          cmd.sort_place = 1'b1;
          state_nxt      = S_SORT_I;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_JM1;
          state_nxt  = S_SORT_C;
        end
      end
      S_DD_I: begin
        if (st.i_ge_n) begin
          cmd.dd_fin = 1'b1;
          state_nxt  = S_OUT;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_I;
          state_nxt  = S_DD_C;
        end
      end
      S_DD_C: begin
        cmd.dd_step = 1'b1;
        state_nxt   = S_DD_I;
      end
      S_MS: begin
        if (st.lo_ge_hi) begin
          state_nxt = S_OUT;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_MID;
          cmd.mid_ld = 1'b1;
          state_nxt  = S_MC;
        end
      end
      S_MC: begin
        cmd.ms_step = 1'b1;
        state_nxt   = st.hit ? S_OUT : S_MS;
      end
      S_OUT: begin
        if (st.out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

[sv/ccm_dp.sv]
// ----------------------------------------------------------------------------
// ccm_dp
// value store, sort and search counters, set state and result register
// ----------------------------------------------------------------------------
module ccm_dp
  import ccm_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic [VW-1:0]   in_value,
  input  cmd_t            cmd,
  output status_t         st,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [AW-1:0]   out_rank,
  output logic            out_found,
  output logic [CW-1:0]   out_unique_count,
  output logic            out_overflow
);

  localparam logic [CW-1:0] CAP = CW'(N_ENTRIES);

  logic [VW-1:0] mem [N_ENTRIES];
  logic [VW-1:0] rdata_r;

  logic [CW-1:0] loaded_r, distinct_r, i_r, w_r, lo_r, hi_r;
  logic          closed_r, ovf_r;
  logic [AW-1:0] j_r, mid_r, rank_r;
  logic          found_r;
  logic [VW-1:0] key_r, last_r, val_r;

  logic          out_valid_r, out_found_r, out_ovf_r;
  logic [AW-1:0] out_rank_r;
  logic [CW-1:0] out_cnt_r;

  logic          we;
  logic [AW-1:0] waddr, raddr, mid_c;
  logic [VW-1:0] wdata;
  logic [CW:0]   lohi_sum;

  assign lohi_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid_c    = lohi_sum[AW:1];

  always_comb begin
    case (cmd.rd_sel)
      RD_I:    raddr = i_r[AW-1:0];
      RD_IM1:  raddr = AW'(i_r - CW'(1));
      RD_JM1:  raddr = j_r - AW'(1);
      RD_MID:  raddr = mid_c;
      default: raddr = i_r[AW-1:0];
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = j_r;
    wdata = key_r;
    if (cmd.ld && (closed_r || loaded_r < CAP)) begin
      we    = 1'b1;
      waddr = closed_r ? '0 : loaded_r[AW-1:0];
      wdata = in_value;
    end else if (cmd.sort_shift) begin
      we    = 1'b1;
      wdata = rdata_r;
    end else if (cmd.sort_place) begin
      we = 1'b1;
    end else if (cmd.dd_step && (w_r == '0 || last_r != rdata_r)) begin
      we    = 1'b1;
      waddr = w_r[AW-1:0];
      wdata = rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  // set state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r   <= '0;
      distinct_r <= '0;
      closed_r   <= 1'b0;
      ovf_r      <= 1'b0;
    end else if (cmd.ld) begin
      if (closed_r) begin
        loaded_r   <= CW'(1);
        distinct_r <= '0;
        closed_r   <= 1'b0;
        ovf_r      <= 1'b0;
      end else if (loaded_r < CAP) begin
        loaded_r <= loaded_r + CW'(1);
      end else begin
        ovf_r <= 1'b1;
      end
    end else if (cmd.dd_fin) begin
      loaded_r   <= w_r;
      distinct_r <= w_r;
      closed_r   <= 1'b1;
    end
  end

  // sort, dedupe and search registers
  always_ff @(posedge clk) begin
    if (cmd.sort_init) i_r <= CW'(1);
    if (cmd.dd_init) begin
      i_r <= '0;
      w_r <= '0;
    end
    if (cmd.key_ld) begin
      key_r <= rdata_r;
      j_r   <= i_r[AW-1:0];
    end
    if (cmd.sort_shift) j_r <= j_r - AW'(1);
    if (cmd.sort_place) i_r <= i_r + CW'(1);
    if (cmd.dd_step) begin
      i_r <= i_r + CW'(1);
      if (w_r == '0 || last_r != rdata_r) begin
        last_r <= rdata_r;
        w_r    <= w_r + CW'(1);
      end
    end
    if (cmd.sort_init || cmd.cap) begin
      found_r <= 1'b0;
      rank_r  <= '0;
    end
    if (cmd.cap) begin
      val_r <= in_value;
      lo_r  <= '0;
      hi_r  <= distinct_r;
    end
    if (cmd.mid_ld) mid_r <= mid_c;
    if (cmd.ms_step) begin
      if (rdata_r == val_r) begin
        found_r <= 1'b1;
        rank_r  <= mid_r;
      end else if (rdata_r < val_r) begin
        lo_r <= {1'b0, mid_r} + CW'(1);
      end else begin
        hi_r <= {1'b0, mid_r};
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_rank_r  <= rank_r;
      out_found_r <= found_r;
      out_cnt_r   <= distinct_r;
      out_ovf_r   <= ovf_r;
    end
  end

  assign st.i_ge_n    = (i_r >= loaded_r);
  assign st.j_zero    = (j_r == '0);
  assign st.rd_gt_key = (rdata_r > key_r);
  assign st.lo_ge_hi  = (lo_r >= hi_r);
  assign st.hit       = (rdata_r == val_r);
  assign st.out_free  = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_rank         = out_rank_r;
  assign out_found        = out_found_r;
  assign out_unique_count = out_cnt_r;
  assign out_overflow     = out_ovf_r;

endmodule

[sv/coordinate_compression_map_unit.sv]
// ----------------------------------------------------------------------------
// coordinate_compression_map_unit
// load, sort with dedupe, and rank lookup of column indices
// ----------------------------------------------------------------------------
// load: no result; one item in flight at a time, input held off while busy
// close: insertion sort through the store, then a dedupe pass; the result
//   register loads last
// map: binary search over the distinct values, stopping on a hit or an empty range
// a finished close or map waits until the result register is free
// reset clears counts and flags; the store needs no clearing pass
module coordinate_compression_map_unit
  import ccm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  ccm_in_if.sink    in_ch,
  ccm_out_if.source out_ch
);

  cmd_t    cmd;
  status_t st;

  ccm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_kind  (in_ch.kind),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  ccm_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_value         (in_ch.value),
    .cmd              (cmd),
    .st               (st),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_rank         (out_ch.rank),
    .out_found        (out_ch.found),
    .out_unique_count (out_ch.unique_count),
    .out_overflow     (out_ch.overflow)
  );

  a_rank_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.found |-> {1'b0, out_ch.rank} < out_ch.unique_count)
    else $error("rank beyond distinct count");

  a_miss_rank_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.found |-> out_ch.rank == '0)
    else $error("miss with nonzero rank");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.unique_count <= CW'(N_ENTRIES))
    else $error("distinct count beyond capacity");

  a_out_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |=> out_ch.valid && !in_ch.ready == 1'b0)
    else $error("result transfer did not return to idle");

endmodule
